### rtl/core/tksp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksp_pkg
// Shared types and constants of the terminal key sequence parser.
// ----------------------------------------------------------------------------
package tksp_pkg;

	localparam int unsigned BUFFER_BYTES = 4096;
	localparam int unsigned POS_W        = 13;
	localparam int unsigned OFS_W        = 12;

	// Byte codes
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CTRL_OR  = 8'h40;
	localparam logic [7:0] CTRL_TOP = 8'h20;

	// Modifier bits
	localparam logic [2:0] MOD_NONE = 3'd0;
	localparam logic [2:0] MOD_CTRL = 3'd1;
	localparam logic [2:0] MOD_META = 3'd2;
	localparam logic [2:0] MOD_SPEC = 3'd4;

	localparam logic [POS_W-1:0] LEFT_MAX = POS_W'(BUFFER_BYTES);

	typedef struct packed {
		logic             first;
		logic [POS_W-1:0] bytes_left;
		logic [7:0]       next_byte;
		logic [7:0]       data_byte;
	} item_t;

	typedef struct packed {
		logic [OFS_W-1:0] key_index;
		logic [POS_W-1:0] key_end;
		logic [OFS_W-1:0] key_start;
		logic [7:0]       key_code;
		logic [2:0]       key_mod;
	} key_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] keys;
		logic [2:0]       pmod;
		logic [7:0]       pcode;
		logic [OFS_W-1:0] pstart;
	} state_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a);
	endfunction

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		if ((b & 8'he0) == 8'hc0) len = 3'd2;
		else if ((b & 8'hf0) == 8'he0) len = 3'd3;
		else if ((b & 8'hf8) == 8'hf0) len = 3'd4;
		else len = 3'd1;
		return len;
	endfunction

endpackage

### rtl/core/terminal_key_sequence_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_sequence_parser
// Turns raw terminal bytes into key events (ctrl, meta, special sequences,
// UTF-8 keys and plain ASCII).
//
//   channel  | dir | payload
//   ---------+-----+--------------------------------------------------
//   s_axis   | in  | one terminal byte with lookahead, count, first flag
//   m_axis   | out | one key event
//
// One byte per cycle while m_axis does not stall. A byte is held in the input
// register, is decoded against the pending key and lands in the result
// register. A stall on m_axis holds the input register, and the input
// register refills while a result waits. Reset clears the counters, the
// pending key and both valid flags.
// ----------------------------------------------------------------------------
module terminal_key_sequence_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // data_byte, next_byte, bytes_left, pad
	input  logic [0:0]  s_axis_tuser,  // first
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // key_mod, key_code, key_start,
	                                   // key_end, key_index
);
	import tksp_pkg::*;

	logic   valid_s1;
	item_t  item_s1;
	state_t state_q;
	logic   valid_s2;
	key_t   key_s2;
	logic   adv;
	logic   emit;
	key_t   key;
	state_t nxt;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	tksp_decode u_decode (
		.item (item_s1),
		.cur  (state_q),
		.emit (emit),
		.key  (key),
		.nxt  (nxt)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data_byte  <= s_axis_tdata[7:0];
			item_s1.next_byte  <= s_axis_tdata[15:8];
			item_s1.bytes_left <= s_axis_tdata[28:16];
			item_s1.first      <= s_axis_tuser[0];
		end
	end

	// Parser state: advance once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= emit;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			key_s2 <= key;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {key_s2.key_index, key_s2.key_end, key_s2.key_start,
		key_s2.key_code, key_s2.key_mod};

endmodule

### rtl/core/tksp_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksp_decode
// Classifies one byte against the pending key and gives the key event, if
// any, together with the parser state after the byte.
// ----------------------------------------------------------------------------
module tksp_decode (
	input  tksp_pkg::item_t  item,
	input  tksp_pkg::state_t cur,
	output logic             emit,
	output tksp_pkg::key_t   key,
	output tksp_pkg::state_t nxt
);
	import tksp_pkg::*;

	state_t           st;
	logic [POS_W-1:0] left;
	logic             more;
	logic [2:0]       len;
	logic [POS_W-1:0] len_w;
	logic [POS_W-1:0] pos_inc;
	logic [7:0]       b;
	logic [7:0]       nx;

	// Clamp the buffer count and start fresh on a new buffer
	always_comb begin
		st = item.first ? '0 : cur;
		b  = item.data_byte;
		nx = item.next_byte;
		if (item.bytes_left == '0) begin
			left = POS_W'(1);
		end else if (item.bytes_left > LEFT_MAX) begin
			left = LEFT_MAX;
		end else begin
			left = item.bytes_left;
		end
		more    = left > POS_W'(1);
		len     = lead_len(b);
		len_w   = (POS_W'(len) > left) ? left : POS_W'(len);
		pos_inc = st.pos + POS_W'(1);
	end

	// Classify the byte
	always_comb begin
		emit          = 1'b0;
		key.key_mod   = MOD_NONE;
		key.key_code  = b;
		key.key_start = st.pos[OFS_W-1:0];
		key.key_end   = pos_inc;
		key.key_index = st.keys[OFS_W-1:0];
		nxt           = st;
		priority if (b == CH_ESC) begin
			nxt.pstart = st.pos[OFS_W-1:0];
			nxt.pmod   = MOD_META;
		end else if (more && is_alnum(nx) && st.pmod[1] &&
			(b == CH_LBRK || b == CH_ZERO)) begin
			nxt.pmod = MOD_SPEC;
		end else if (b == CH_DEL) begin
			emit         = 1'b1;
			key.key_mod  = st.pmod | MOD_CTRL;
			key.key_code = CH_QUEST;
		end else if (b < CTRL_TOP) begin
			emit         = 1'b1;
			key.key_mod  = st.pmod | MOD_CTRL;
			key.key_code = b | CTRL_OR;
		end else if (st.pmod[2] && b == CH_TILDE) begin
			emit          = 1'b1;
			key.key_mod   = st.pmod;
			key.key_code  = st.pcode;
			key.key_start = st.pstart;
		end else if (st.pmod[1] || st.pmod[2]) begin
			nxt.pcode     = b;
			emit          = st.pmod[1] || (nx != CH_TILDE);
			key.key_mod   = st.pmod;
			key.key_start = st.pstart;
		end else if (b[7:6] == 2'b10) begin
			// continuation byte: drop
			emit = 1'b0;
		end else if (b[7:6] == 2'b11) begin
			emit         = 1'b1;
			key.key_code = 8'd0;
			key.key_end  = st.pos + len_w;
		end else begin
			emit = 1'b1;
		end

		// Advance counters and clear the pending key after an event
		nxt.pos = pos_inc;
		if (emit) begin
			nxt.keys   = st.keys + POS_W'(1);
			nxt.pmod   = MOD_NONE;
			nxt.pcode  = 8'd0;
			nxt.pstart = '0;
		end
	end

endmodule
